// ===== src/resource_handle_registry_defines.svh =====
// assertion macros for the resource handle registry
// used by modules that check their own control logic; needs clk and arst_n in scope
`ifndef RESOURCE_HANDLE_REGISTRY_DEFINES_SVH
`define RESOURCE_HANDLE_REGISTRY_DEFINES_SVH
`ifndef SYNTHESIS
`define RHR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RHR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RHR_ASSERT(label, prop, msg)
`define RHR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/rhr_pkg.sv =====
// shared types and constants of the resource handle registry
// no dependencies
`default_nettype none
package rhr_pkg;

	localparam int TABLE_DEPTH_DEF = 128;
	localparam logic [15:0] SLOT_LIMIT_RST = 16'd32;

	typedef enum logic [1:0] {
		REQ_REGISTER   = 2'd0,
		REQ_UNREGISTER = 2'd1,
		REQ_RESOLVE    = 2'd2,
		REQ_CLEAR      = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_REJECTED  = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	// one stored table entry
	typedef struct packed {
		logic [15:0] opaque;
		logic [31:0] native;
		logic [7:0]  rtype;
		logic [7:0]  life;
		logic [15:0] slot;
		logic [15:0] key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// one incoming request item
	typedef struct packed {
		req_type_t   req_type;
		logic [7:0]  res_type;
		logic [15:0] slot;
		logic [15:0] res_key;
		logic [7:0]  lifetime;
		logic [31:0] backend_id;
		logic [15:0] lookup_id;
	} req_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [15:0] handle_id;
		logic [31:0] resolved_native;
	} result_t;

endpackage
`default_nettype wire

// ===== src/resource_handle_registry.sv =====
// Resource handle registry: a table of up to TABLE_DEPTH entries, each mapping a
// slot or key to an opaque 16-bit id and a 32-bit native id.
// Input channel: in_valid / in_stall with one port per request field; an item is
// taken at a clock edge with in_valid high and in_stall low. Requests are served
// one at a time: register, unregister, resolve, or clear the table.
// Output channel: out_valid / out_stall, one result item per request, held in an
// output register. When the receiver stalls, the finished result waits there and
// the next request is still taken and processed; a second finished result then
// waits inside the sequencer until the output register frees up.
// A rejected register or a clear goes from idle straight to the done state; any other
// request passes through the scan and apply states, and an unregister that finds its
// entry also through the move read and move write states before done. The table scan
// stops at a hit or after the last live entry and reads one entry per cycle through
// the single read port of the entry memory.
// Only one request is in flight; the next item is taken in the cycle after the
// previous result leaves the sequencer. The user writes slot_limit through cfg_we /
// cfg_wdata only while the block is idle; the block itself does not enforce this.
// Reset: the table is empty, the next opaque id is 1 and slot_limit is 32; the
// memory itself needs no clearing since only entries below the count are read.
// depends on rhr_pkg, rhr_ram, rhr_ctrl
`default_nettype none
module resource_handle_registry #(
	parameter int TABLE_DEPTH = rhr_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [7:0]  res_type,
	input  wire logic [15:0] slot,
	input  wire logic [15:0] res_key,
	input  wire logic [7:0]  lifetime,
	input  wire logic [31:0] backend_id,
	input  wire logic [15:0] lookup_id,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [15:0]      handle_id,
	output logic [31:0]      resolved_native,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	rhr_pkg::req_t              req;
	rhr_pkg::result_t           fin;
	logic                       req_ready;
	logic                       fin_valid;
	logic                       fin_take;
	logic [15:0]                slot_limit_q;
	logic                       out_valid_q;
	rhr_pkg::result_t           out_q;
	logic                       mem_we;
	logic [IDX_W-1:0]           mem_waddr;
	logic [rhr_pkg::ENTRY_W-1:0] mem_wdata;
	logic                       mem_re;
	logic [IDX_W-1:0]           mem_raddr;
	logic [rhr_pkg::ENTRY_W-1:0] mem_rdata;

	// request item from the ports
	always_comb begin
		req.req_type   = rhr_pkg::req_type_t'(req_type);
		req.res_type   = res_type;
		req.slot       = slot;
		req.res_key    = res_key;
		req.lifetime   = lifetime;
		req.backend_id = backend_id;
		req.lookup_id  = lookup_id;
	end

	assign in_stall = !req_ready;

	// slot limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_limit_q <= rhr_pkg::SLOT_LIMIT_RST;
		end else if (cfg_we) begin
			slot_limit_q <= cfg_wdata;
		end
	end

	// output register, loads when empty or being drained
	assign fin_take = fin_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_take) begin
			out_q <= fin;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign handle_id       = out_q.handle_id;
	assign resolved_native = out_q.resolved_native;

	rhr_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_valid  (in_valid),
		.req_ready  (req_ready),
		.slot_limit (slot_limit_q),
		.fin_valid  (fin_valid),
		.fin        (fin),
		.fin_take   (fin_take),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

	rhr_ram #(
		.WIDTH(rhr_pkg::ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_entry_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

// ===== src/rhr_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none
module rhr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/rhr_ctrl.sv =====
// request sequencer: scans the entry table, applies register/unregister/resolve/clear
// depends on rhr_pkg and resource_handle_registry_defines.svh
`default_nettype none
`include "resource_handle_registry_defines.svh"
module rhr_ctrl #(
	parameter int TABLE_DEPTH = rhr_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rhr_pkg::req_t                        req,
	input  wire logic                                 req_valid,
	output logic                                      req_ready,
	input  wire logic [15:0]                          slot_limit,
	output logic                                      fin_valid,
	output rhr_pkg::result_t                          fin,
	input  wire logic                                 fin_take,
	output logic                                      mem_we,
	output logic [$clog2(TABLE_DEPTH)-1:0]            mem_waddr,
	output logic [rhr_pkg::ENTRY_W-1:0]               mem_wdata,
	output logic                                      mem_re,
	output logic [$clog2(TABLE_DEPTH)-1:0]            mem_raddr,
	input  wire logic [rhr_pkg::ENTRY_W-1:0]          mem_rdata
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

	rhr_pkg::state_t  state_q, state_d;
	rhr_pkg::req_t    req_q, req_d;
	rhr_pkg::result_t res_q, res_d;
	rhr_pkg::entry_t  rd_entry, hit_entry_q, hit_entry_d, new_entry;
	logic [CNT_W-1:0] count_q, count_d;
	logic [15:0]      next_id_q, next_id_d;
	logic [CNT_W-1:0] scan_idx_q, scan_idx_d;
	logic             pend_s1, pend_d;
	logic [IDX_W-1:0] idx_s1, idx_d;
	logic             found_q, found_d;
	logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
	logic [CNT_W-1:0] last_idx;
	logic             slot_ok;
	logic             hit_cond;
	logic             hit;
	logic [15:0]      new_id;
	logic [15:0]      new_next_id;

	assign rd_entry = rhr_pkg::entry_t'(mem_rdata);
	assign last_idx = count_q - CNT_W'(1);
	assign fin      = res_q;

	// entry match against the item being served
	always_comb begin
		slot_ok = (req_q.slot != 16'd0) && (req_q.slot < slot_limit);
		case (req_q.req_type)
			rhr_pkg::REQ_RESOLVE: begin
				hit_cond = (req_q.lookup_id != 16'd0) && (rd_entry.opaque == req_q.lookup_id);
			end
			default: begin
				if (req_q.slot != 16'd0) begin
					hit_cond = slot_ok && (rd_entry.slot == req_q.slot);
				end else begin
					hit_cond = (req_q.res_key != 16'd0) && (rd_entry.key == req_q.res_key);
				end
			end
		endcase
		hit = pend_s1 && hit_cond;
	end

	// next opaque id, skipping zero
	always_comb begin
		if (next_id_q == 16'd0) begin
			new_id      = 16'd1;
			new_next_id = 16'd2;
		end else begin
			new_id      = next_id_q;
			new_next_id = next_id_q + 16'd1;
		end
	end

	// fields written by a register item
	always_comb begin
		new_entry.opaque = found_q ? hit_entry_q.opaque : new_id;
		new_entry.native = req_q.backend_id;
		new_entry.rtype  = req_q.res_type;
		new_entry.life   = req_q.lifetime;
		new_entry.slot   = req_q.slot;
		new_entry.key    = req_q.res_key;
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		req_d       = req_q;
		res_d       = res_q;
		count_d     = count_q;
		next_id_d   = next_id_q;
		scan_idx_d  = scan_idx_q;
		pend_d      = 1'b0;
		idx_d       = idx_s1;
		found_d     = found_q;
		hit_idx_d   = hit_idx_q;
		hit_entry_d = hit_entry_q;
		req_ready   = 1'b0;
		fin_valid   = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = hit_idx_q;
		mem_wdata   = new_entry;
		mem_re      = 1'b0;
		mem_raddr   = scan_idx_q[IDX_W-1:0];
		case (state_q)
			rhr_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					req_d = req;
					res_d.status          = rhr_pkg::ST_OK;
					res_d.handle_id       = 16'd0;
					res_d.resolved_native = 32'd0;
					scan_idx_d            = '0;
					if (req.req_type == rhr_pkg::REQ_CLEAR) begin
						count_d   = '0;
						next_id_d = 16'd1;
						state_d   = rhr_pkg::S_DONE;
					end else if (req.req_type == rhr_pkg::REQ_REGISTER &&
							(req.res_type == 8'd0 || req.backend_id == 32'd0)) begin
						res_d.status = rhr_pkg::ST_REJECTED;
						state_d      = rhr_pkg::S_DONE;
					end else begin
						state_d = rhr_pkg::S_SCAN;
					end
				end
			end
			rhr_pkg::S_SCAN: begin
				if (hit) begin
					found_d     = 1'b1;
					hit_idx_d   = idx_s1;
					hit_entry_d = rd_entry;
					state_d     = rhr_pkg::S_APPLY;
				end else if (scan_idx_q == count_q) begin
					found_d = 1'b0;
					state_d = rhr_pkg::S_APPLY;
				end else begin
					mem_re     = 1'b1;
					pend_d     = 1'b1;
					idx_d      = scan_idx_q[IDX_W-1:0];
					scan_idx_d = scan_idx_q + CNT_W'(1);
				end
			end
			rhr_pkg::S_APPLY: begin
				state_d = rhr_pkg::S_DONE;
				case (req_q.req_type)
					rhr_pkg::REQ_REGISTER: begin
						if (found_q) begin
							mem_we          = 1'b1;
							res_d.handle_id = hit_entry_q.opaque;
						end else if (count_q == FULL_CNT) begin
							res_d.status = rhr_pkg::ST_FULL;
						end else begin
							mem_we          = 1'b1;
							mem_waddr       = count_q[IDX_W-1:0];
							count_d         = count_q + CNT_W'(1);
							next_id_d       = new_next_id;
							res_d.handle_id = new_id;
						end
					end
					rhr_pkg::REQ_UNREGISTER: begin
						if (found_q) begin
							state_d = rhr_pkg::S_MOVE_RD;
						end else begin
							res_d.status = rhr_pkg::ST_NOT_FOUND;
						end
					end
					rhr_pkg::REQ_RESOLVE: begin
						if (found_q) begin
							res_d.resolved_native = hit_entry_q.native;
						end else begin
							res_d.status = rhr_pkg::ST_NOT_FOUND;
						end
					end
					default: begin
						res_d.status = rhr_pkg::ST_OK;
					end
				endcase
			end
			rhr_pkg::S_MOVE_RD: begin
				// fetch the last entry to fill the freed place
				mem_re    = 1'b1;
				mem_raddr = last_idx[IDX_W-1:0];
				state_d   = rhr_pkg::S_MOVE_WR;
			end
			rhr_pkg::S_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				count_d   = last_idx;
				state_d   = rhr_pkg::S_DONE;
			end
			rhr_pkg::S_DONE: begin
				fin_valid = 1'b1;
				if (fin_take) begin
					state_d = rhr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rhr_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rhr_pkg::S_IDLE;
			count_q   <= '0;
			next_id_q <= 16'd1;
			pend_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			next_id_q <= next_id_d;
			pend_s1   <= pend_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		req_q       <= req_d;
		res_q       <= res_d;
		scan_idx_q  <= scan_idx_d;
		idx_s1      <= idx_d;
		found_q     <= found_d;
		hit_idx_q   <= hit_idx_d;
		hit_entry_q <= hit_entry_d;
	end

	`RHR_ASSERT(a_count_bound, count_q <= FULL_CNT, "entry count above table depth")
	`RHR_ASSERT(a_one_access, !(mem_we && mem_re), "table read and written in one cycle")
	`RHR_ASSERT(a_full_real, !(fin_valid && fin.status == rhr_pkg::ST_FULL) || count_q == FULL_CNT, "table full reported on a table with room")
	`RHR_ASSERT_NEXT(a_clear, state_q == rhr_pkg::S_IDLE && req_valid && req.req_type == rhr_pkg::REQ_CLEAR, count_q == '0 && next_id_q == 16'd1, "clear item did not empty the table")

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// testbench for resource_handle_registry: directed and random request streams with
// bursty sending and patterned output stalls, every result checked against a local model
// depends on rhr_pkg and the resource_handle_registry rtl
module tb_top;

	localparam int DEPTH = rhr_pkg::TABLE_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1280;
	localparam int MAX_REPORTS = 10;

	typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = 2'd0;
	logic [7:0]  res_type = 8'd0;
	logic [15:0] slot = 16'd0;
	logic [15:0] res_key = 16'd0;
	logic [7:0]  lifetime = 8'd0;
	logic [31:0] backend_id = 32'd0;
	logic [15:0] lookup_id = 16'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [15:0] handle_id;
	logic [31:0] resolved_native;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = 16'd0;

	// registry model state
	rhr_pkg::entry_t tbl [DEPTH];
	int unsigned     n_entries;
	logic [15:0]     mdl_next_id;
	logic [15:0]     slot_lim;

	rhr_pkg::result_t pending_results [$];
	int               err_count = 0;
	int               result_no = 0;

	// idling control
	bit    pace_on = 1'b1;
	int    burst_left = 0;
	int    stall_left = 0;
	pace_t stall_pace = PACE_FREE;

	resource_handle_registry DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.res_type(res_type),
		.slot(slot),
		.res_key(res_key),
		.lifetime(lifetime),
		.backend_id(backend_id),
		.lookup_id(lookup_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.handle_id(handle_id),
		.resolved_native(resolved_native),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// lookups only look at live entries; out-of-range slots never match
	function automatic int find_slot(input logic [15:0] s);
		if (s == 16'd0 || s >= slot_lim)
			return -1;
		for (int i = 0; i < n_entries; i++)
			if (tbl[i].slot == s)
				return i;
		return -1;
	endfunction

	function automatic int find_key(input logic [15:0] k);
		if (k == 16'd0)
			return -1;
		for (int i = 0; i < n_entries; i++)
			if (tbl[i].key == k)
				return i;
		return -1;
	endfunction

	// applies one request to the model and returns the result it should produce
	function automatic rhr_pkg::result_t registry_apply(input rhr_pkg::req_t r);
		rhr_pkg::result_t res;
		int idx;
		res = '0;
		res.status = rhr_pkg::ST_OK;
		case (r.req_type)
			rhr_pkg::REQ_REGISTER: begin
				if (r.res_type == 8'd0 || r.backend_id == 32'd0) begin
					res.status = rhr_pkg::ST_REJECTED;
				end else begin
					idx = (r.slot != 16'd0) ? find_slot(r.slot) : find_key(r.res_key);
					if (idx < 0 && n_entries >= DEPTH) begin
						res.status = rhr_pkg::ST_FULL;
					end else begin
						if (idx < 0) begin
							// new handle, counting modulo 2^16 without zero
							idx = n_entries;
							n_entries++;
							tbl[idx] = '0;
							if (mdl_next_id == 16'd0)
								mdl_next_id = 16'd1;
							tbl[idx].opaque = mdl_next_id;
							mdl_next_id = mdl_next_id + 16'd1;
						end
						tbl[idx].native = r.backend_id;
						tbl[idx].rtype = r.res_type;
						tbl[idx].life = r.lifetime;
						tbl[idx].slot = r.slot;
						tbl[idx].key = r.res_key;
						res.handle_id = tbl[idx].opaque;
					end
				end
			end
			rhr_pkg::REQ_UNREGISTER: begin
				idx = (r.slot != 16'd0) ? find_slot(r.slot) : find_key(r.res_key);
				if (idx < 0) begin
					res.status = rhr_pkg::ST_NOT_FOUND;
				end else begin
					tbl[idx] = tbl[n_entries - 1];
					n_entries--;
				end
			end
			rhr_pkg::REQ_RESOLVE: begin
				res.status = rhr_pkg::ST_NOT_FOUND;
				if (r.lookup_id != 16'd0) begin
					for (int i = 0; i < n_entries; i++) begin
						if (tbl[i].opaque == r.lookup_id) begin
							res.status = rhr_pkg::ST_OK;
							res.resolved_native = tbl[i].native;
							break;
						end
					end
				end
			end
			default: begin
				n_entries = 0;
				mdl_next_id = 16'd1;
			end
		endcase
		return res;
	endfunction

	// result checker
	always @(posedge clk) begin : check_results
		rhr_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			result_no++;
			if (pending_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("result %0d with nothing pending: %0d %04h %08h",
						result_no, status, handle_id, resolved_native);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || handle_id !== want.handle_id ||
						resolved_native !== want.resolved_native) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("result %0d: want %0d %04h %08h, got %0d %04h %08h",
							result_no, want.status, want.handle_id,
							want.resolved_native, status, handle_id, resolved_native);
				end
			end
		end
	end

	// receiver stall pattern: free, light, heavy or periodic, picked anew at random
	always @(posedge clk) begin
		if (!pace_on) begin
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0) begin
				stall_pace = pace_t'($urandom_range(0, 3));
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			case (stall_pace)
				PACE_FREE:     out_stall <= 1'b0;
				PACE_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				PACE_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				PACE_PERIODIC: out_stall <= ((stall_left % 7) < 3);
			endcase
		end
	end

	// sends one item in bursts with random gaps, then predicts its result
	task automatic send_item(input rhr_pkg::req_t r);
		int gap;
		if (pace_on && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = $urandom_range(0, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		in_valid <= 1'b1;
		req_type <= r.req_type;
		res_type <= r.res_type;
		slot <= r.slot;
		res_key <= r.res_key;
		lifetime <= r.lifetime;
		backend_id <= r.backend_id;
		lookup_id <= r.lookup_id;
		do
			@(posedge clk);
		while (in_stall);
		pending_results.push_back(registry_apply(r));
	endtask

	// unused fields of each request carry random values
	function automatic rhr_pkg::req_t noise_req();
		rhr_pkg::req_t r;
		r.req_type = rhr_pkg::req_type_t'($urandom_range(0, 3));
		r.res_type = 8'($urandom);
		r.slot = 16'($urandom);
		r.res_key = 16'($urandom);
		r.lifetime = 8'($urandom);
		r.backend_id = $urandom;
		r.lookup_id = 16'($urandom);
		return r;
	endfunction

	task automatic do_register(input logic [7:0] ty, input logic [15:0] sl,
			input logic [15:0] k, input logic [7:0] life, input logic [31:0] nat);
		rhr_pkg::req_t r;
		r = noise_req();
		r.req_type = rhr_pkg::REQ_REGISTER;
		r.res_type = ty;
		r.slot = sl;
		r.res_key = k;
		r.lifetime = life;
		r.backend_id = nat;
		send_item(r);
	endtask

	task automatic do_unregister(input logic [15:0] sl, input logic [15:0] k);
		rhr_pkg::req_t r;
		r = noise_req();
		r.req_type = rhr_pkg::REQ_UNREGISTER;
		r.slot = sl;
		r.res_key = k;
		send_item(r);
	endtask

	task automatic do_resolve(input logic [15:0] id);
		rhr_pkg::req_t r;
		r = noise_req();
		r.req_type = rhr_pkg::REQ_RESOLVE;
		r.lookup_id = id;
		send_item(r);
	endtask

	task automatic do_clear();
		rhr_pkg::req_t r;
		r = noise_req();
		r.req_type = rhr_pkg::REQ_CLEAR;
		send_item(r);
	endtask

	// drains all results, then writes slot_limit with the block idle
	task automatic write_slot_limit(input logic [15:0] v);
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		slot_lim = v;
	endtask

	// random request: mostly well-formed traffic on small slot and key pools
	function automatic rhr_pkg::req_t draw_request();
		rhr_pkg::req_t r;
		rhr_pkg::entry_t e;
		int pick;
		int hi;
		r = noise_req();
		if ($urandom_range(0, 7) == 0)
			return r;
		pick = $urandom_range(0, 99);
		if (pick < 48)
			r.req_type = rhr_pkg::REQ_REGISTER;
		else if (pick < 70)
			r.req_type = rhr_pkg::REQ_UNREGISTER;
		else if (pick < 99)
			r.req_type = rhr_pkg::REQ_RESOLVE;
		else
			r.req_type = rhr_pkg::REQ_CLEAR;
		// occasional rejected registers
		if ($urandom_range(0, 24) == 0)
			r.res_type = 8'd0;
		else if (r.res_type == 8'd0)
			r.res_type = 8'd1;
		if ($urandom_range(0, 24) == 0)
			r.backend_id = 32'd0;
		// slot or key of a stored entry half the time
		hi = int'(slot_lim) + 1;
		if (hi > 40)
			hi = 40;
		if (n_entries > 0 && $urandom_range(0, 1) == 0) begin
			e = tbl[$urandom_range(0, n_entries - 1)];
			r.slot = ($urandom_range(0, 1) == 0) ? 16'd0 : e.slot;
			r.res_key = e.key;
		end else begin
			r.slot = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, hi));
			r.res_key = 16'($urandom_range(0, 40));
		end
		if ($urandom_range(0, 15) == 0)
			r.slot = 16'($urandom);
		// resolve a live id most of the time
		if (n_entries > 0 && $urandom_range(0, 3) != 0)
			r.lookup_id = tbl[$urandom_range(0, n_entries - 1)].opaque;
		else if ($urandom_range(0, 1) == 0)
			r.lookup_id = 16'($urandom_range(0, 200));
		return r;
	endfunction

	task automatic test_empty_table();
		do_resolve(16'd1);
		do_resolve(16'd0);
		do_unregister(16'd5, 16'd0);
		do_unregister(16'd0, 16'd7);
		do_register(8'd0, 16'd1, 16'd0, 8'd1, 32'd5);
		do_register(8'd3, 16'd1, 16'd0, 8'd1, 32'd0);
	endtask

	task automatic test_register_paths();
		do_register(8'hFF, 16'd1, 16'd0, 8'h00, 32'hFFFF_FFFF);
		do_register(8'h01, 16'd31, 16'hFFFF, 8'hFF, 32'h0000_0001);
		// by key, overwrites and stores slot 0
		do_register(8'h80, 16'd0, 16'hFFFF, 8'h55, 32'h8000_0000);
		// slot at the limit and slot at maximum both append
		do_register(8'h10, 16'd32, 16'd5, 8'h0F, 32'h1234_5678);
		do_register(8'h20, 16'hFFFF, 16'd0, 8'hF0, 32'hA5A5_A5A5);
		// neither slot nor key can match
		do_register(8'h30, 16'd0, 16'd0, 8'hAA, 32'h5A5A_5A5A);
		do_register(8'h40, 16'd1, 16'd9, 8'h01, 32'h0F0F_0F0F);
		do_resolve(16'd1);
		do_resolve(16'hFFFF);
		do_unregister(16'd32, 16'd5);
		do_unregister(16'd1, 16'd0);
		do_resolve(16'd5);
		do_unregister(16'd0, 16'hFFFF);
		do_unregister(16'd0, 16'd0);
		do_clear();
		do_register(8'h02, 16'd2, 16'd2, 8'h02, 32'h0000_0202);
	endtask

	task automatic test_slot_limit();
		write_slot_limit(16'd1);
		do_register(8'h05, 16'd1, 16'd0, 8'h05, 32'h0000_0505);
		do_register(8'h06, 16'd1, 16'd0, 8'h06, 32'h0000_0606);
		do_unregister(16'd1, 16'd0);
		write_slot_limit(16'hFFFF);
		do_register(8'h07, 16'hFFFE, 16'd0, 8'h07, 32'h0000_0707);
		do_register(8'h08, 16'hFFFE, 16'd0, 8'h08, 32'h0000_0808);
		do_unregister(16'hFFFE, 16'd0);
		write_slot_limit(rhr_pkg::SLOT_LIMIT_RST);
	endtask

	task automatic test_capacity();
		do_clear();
		for (int i = 1; i <= DEPTH; i++)
			do_register(8'($urandom_range(1, 255)), 16'd0, 16'(i), 8'($urandom),
				$urandom | 32'd1);
		// no room for new keys or out-of-range slots; a zero resource type is still rejected
		do_register(8'h07, 16'd0, 16'(DEPTH + 1), 8'h03, 32'h0000_CAFE);
		do_register(8'h07, 16'hFFFF, 16'd0, 8'h03, 32'h0000_CAFE);
		do_register(8'h00, 16'd0, 16'(DEPTH + 1), 8'h03, 32'h0000_CAFE);
		// overwrite still works when full
		do_register(8'h09, 16'd0, 16'(DEPTH), 8'h04, 32'hCAFE_0001);
		do_resolve(16'(DEPTH));
		do_unregister(16'd0, 16'd1);
		do_register(8'h0A, 16'd0, 16'(DEPTH + 1), 8'h05, 32'h0000_BEEF);
		do_resolve(16'(DEPTH + 1));
		do_resolve(16'd1);
	endtask

	task automatic test_random_traffic();
		logic [15:0] lim;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: lim = 16'd1;
				1: lim = 16'hFFFF;
				2: lim = 16'($urandom_range(2, 64));
				3: lim = 16'($urandom_range(1, 65535));
				default: lim = rhr_pkg::SLOT_LIMIT_RST;
			endcase
			write_slot_limit(lim);
			repeat (RANDOM_ITEMS / 5)
				send_item(draw_request());
		end
	endtask

	initial begin
		n_entries = 0;
		mdl_next_id = 16'd1;
		slot_lim = rhr_pkg::SLOT_LIMIT_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_table();
		test_register_paths();
		test_slot_limit();
		test_capacity();
		test_random_traffic();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 16) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hang guard
	initial begin
		#60_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
